// ===== rtl/core/pdly_pkg.sv =====
// ---------------------------------------------------------------------------
// pdly_pkg: shared types and constants for the presence qualifier
// Holds the default tick modulus, field widths and the pipeline item type.
// ---------------------------------------------------------------------------
`default_nettype none

package pdly_pkg;

    // tick field width and default modulus of the tick counter
    localparam int TICK_W                = 16;
    localparam int TIMER_MODULUS_DEFAULT = 60000;

    // width of the delay registers and of the config data port
    localparam int DELAY_W = 16;
    localparam int CFG_W   = 16;

    // config register indexes
    localparam logic CFG_ON_DELAY  = 1'b0;
    localparam logic CFG_OFF_DELAY = 1'b1;

    // one sample travelling through the pipeline
    typedef struct packed {
        logic              sensor_level;
        logic [TICK_W-1:0] tick;
    } pdly_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdly_tick_reduce.sv =====
// ---------------------------------------------------------------------------
// pdly_tick_reduce: input register and tick reduction
// Registers each request and reduces its tick modulo the timer modulus
// by a reciprocal multiply, then a constant multiply and subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module pdly_tick_reduce
    import pdly_pkg::*;
#(
    parameter int TIMER_MODULUS = TIMER_MODULUS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire pdly_item_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output pdly_item_t      out_item
);

    // reciprocal exact for every 16-bit numerator
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(TIMER_MODULUS) + 64'd1;
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [TICK_W-1:0] MOD_C = TICK_W'(TIMER_MODULUS);

    logic              s1_valid_reg;
    pdly_item_t        s1_item_reg;
    logic              s2_valid_reg;
    pdly_item_t        s2_item_reg;
    logic [TICK_W-1:0] s2_quot_reg;
    logic              s3_valid_reg;
    pdly_item_t        s3_item_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic [47:0]       prod;
    logic [TICK_W-1:0] quot_next;
    logic [31:0]       back_prod;
    logic [TICK_W-1:0] rem_next;

    // per-stage ready so bubbles collapse
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // quotient estimate from the reciprocal
    assign prod      = 48'(s1_item_reg.tick) * 48'(RECIP);
    assign quot_next = prod[47:32];

    // remainder from the registered quotient
    assign back_prod = 32'(s2_quot_reg) * 32'(MOD_C);
    assign rem_next  = s2_item_reg.tick - back_prod[TICK_W-1:0];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_item_reg <= in_item;
        end
        if (s2_ready) begin
            s2_item_reg <= s1_item_reg;
            s2_quot_reg <= quot_next;
        end
        if (s3_ready) begin
            s3_item_reg.sensor_level <= s2_item_reg.sensor_level;
            s3_item_reg.tick         <= rem_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pdly_qualify.sv =====
// ---------------------------------------------------------------------------
// pdly_qualify: on/off delay state and result register
// Runs the on and off timers on reduced ticks and registers the
// qualified level for each request.
// ---------------------------------------------------------------------------
`default_nettype none

module pdly_qualify
    import pdly_pkg::*;
#(
    parameter int TIMER_MODULUS = TIMER_MODULUS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [DELAY_W-1:0] on_delay,
    input  wire logic [DELAY_W-1:0] off_delay,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pdly_item_t         in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_level
);

    localparam logic [TICK_W:0] MOD_X = (TICK_W+1)'(TIMER_MODULUS);

    logic              initialized_reg, initialized_next;
    logic              level_set_reg, level_set_next;
    logic              on_pending_reg, on_pending_next;
    logic              off_pending_reg, off_pending_next;
    logic [TICK_W-1:0] start_tick_reg, start_tick_next;
    logic              out_valid_reg;
    logic              out_level_reg;

    logic              take;
    logic              level_eff;
    logic [TICK_W:0]   diff;
    logic [TICK_W:0]   wrapped;
    logic [TICK_W-1:0] elapsed;
    logic              on_done;
    logic              off_done;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // elapsed ticks since the running timer started, wrapped at the modulus
    assign diff    = {1'b0, in_item.tick} - {1'b0, start_tick_reg};
    assign wrapped = diff + MOD_X;
    assign elapsed = diff[TICK_W] ? wrapped[TICK_W-1:0] : diff[TICK_W-1:0];
    assign on_done  = elapsed > on_delay;
    assign off_done = elapsed > off_delay;

    // timer state update for one sample
    always_comb begin
        initialized_next = 1'b1;
        level_eff        = level_set_reg || (!initialized_reg && in_item.sensor_level);
        level_set_next   = level_eff;
        on_pending_next  = on_pending_reg;
        off_pending_next = off_pending_reg;
        start_tick_next  = start_tick_reg;
        if (in_item.sensor_level) begin
            off_pending_next = 1'b0;
            if (!level_eff) begin
                if (!on_pending_reg) begin
                    on_pending_next = 1'b1;
                    start_tick_next = in_item.tick;
                end else if (on_done) begin
                    on_pending_next = 1'b0;
                    level_set_next  = 1'b1;
                end
            end
        end else begin
            on_pending_next = 1'b0;
            if (level_eff) begin
                if (!off_pending_reg) begin
                    off_pending_next = 1'b1;
                    start_tick_next  = in_item.tick;
                end else if (off_done) begin
                    off_pending_next = 1'b0;
                    level_set_next   = 1'b0;
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initialized_reg <= 1'b0;
            level_set_reg   <= 1'b0;
            on_pending_reg  <= 1'b0;
            off_pending_reg <= 1'b0;
            start_tick_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (take) begin
                initialized_reg <= initialized_next;
                level_set_reg   <= level_set_next;
                on_pending_reg  <= on_pending_next;
                off_pending_reg <= off_pending_next;
                start_tick_reg  <= start_tick_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            out_level_reg <= level_set_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;

endmodule

`default_nettype wire

// ===== rtl/core/presence_sensor_on_off_delay.sv =====
// ---------------------------------------------------------------------------
// presence_sensor_on_off_delay: presence sensor qualifier with on/off delays
// Each request carries a raw sensor level and a tick value; each returns
// one qualified level. An active sensor must outlast on_delay ticks before
// the output sets, an inactive one must outlast off_delay before it clears.
//
// Channels: s_valid/s_ready with s_sensor_level and s_now_tick in,
// m_valid/m_ready with m_qualified_level out. Config: cfg_wr_en with
// cfg_index (0 = on_delay, 1 = off_delay) and cfg_wdata, written at once;
// write only while no request is in flight.
// Result path: input register, reciprocal multiply, constant multiply and
// subtract, timer state and result register. Throughput: one request per
// cycle while the receiver does not hold m_ready low.
// Reset clears both delays and all timer state; the first request after
// reset sets the output at once if the sensor is active.
// A stalled receiver holds the result; each stage keeps accepting until
// it is full, then s_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module presence_sensor_on_off_delay
    import pdly_pkg::*;
#(
    parameter int TIMER_MODULUS = TIMER_MODULUS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_sensor_level,
    input  wire logic [TICK_W-1:0] s_now_tick,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_qualified_level,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    logic [DELAY_W-1:0] on_delay_reg;
    logic [DELAY_W-1:0] off_delay_reg;
    pdly_item_t         in_item;
    pdly_item_t         red_item;
    logic               red_valid;
    logic               red_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_delay_reg  <= '0;
            off_delay_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ON_DELAY:  on_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                CFG_OFF_DELAY: off_delay_reg <= cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.sensor_level = s_sensor_level;
    assign in_item.tick         = s_now_tick;

    // input register and tick reduction
    pdly_tick_reduce #(
        .TIMER_MODULUS(TIMER_MODULUS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_item  (red_item)
    );

    // timer state and result register
    pdly_qualify #(
        .TIMER_MODULUS(TIMER_MODULUS)
    ) u_qualify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .on_delay  (on_delay_reg),
        .off_delay (off_delay_reg),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_item   (red_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_level (m_qualified_level)
    );

endmodule

`default_nettype wire

// ===== bench/tb_presence_sensor_on_off_delay.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_presence_sensor_on_off_delay: self-checking bench for the presence qualifier
// Drives sensor samples with running tick values through the request channel,
// predicts every qualified level in a local model of the on/off timers and
// compares each result in order. Runs directed corner cases, then sensor
// traffic under several delay settings with random gaps, a long receiver
// hold-off and a full drain pause.
// ---------------------------------------------------------------------------

module tb_presence_sensor_on_off_delay;
    import pdly_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 40;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_sensor_level = 1'b0;
    logic [TICK_W-1:0] s_now_tick = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_qualified_level;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = CFG_ON_DELAY;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // idle rates in percent and bookkeeping
    int send_idle_pct = 19;
    int recv_idle_pct = 56;
    int error_count = 0;
    int cycle_count = 0;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left = 0;

    // predicted qualified levels waiting for their result
    bit expected_levels[$];
    bit want_level;

    // local copy of the delay registers and timer state
    logic [DELAY_W-1:0] on_delay_reg = '0;
    logic [DELAY_W-1:0] off_delay_reg = '0;
    bit                 qual_init = 1'b0;
    bit                 qual_set = 1'b0;
    bit                 on_timing = 1'b0;
    bit                 off_timing = 1'b0;
    int unsigned        timer_start = 0;

    // sensor traffic generator state
    int   trace_tick = 0;
    logic trace_level = 1'b0;
    int   run_left = 0;

    presence_sensor_on_off_delay u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sensor_level    (s_sensor_level),
        .s_now_tick        (s_now_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_qualified_level (m_qualified_level),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_presence_sensor_on_off_delay: FAIL");
            $finish;
        end
    end

    // result receiver: random idling, long hold-off on demand
    always @(posedge aclk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // qualified level after one sample, updates the timer state
    function automatic bit qualify_sample(input logic level, input logic [TICK_W-1:0] raw);
        int unsigned now;
        int unsigned elapsed;
        now = raw % TIMER_MODULUS_DEFAULT;
        elapsed = (now + TIMER_MODULUS_DEFAULT - timer_start) % TIMER_MODULUS_DEFAULT;
        // first sample after reset sets at once when active
        if (!qual_init) begin
            qual_init = 1'b1;
            if (level)
                qual_set = 1'b1;
        end
        if (level) begin
            off_timing = 1'b0;
            if (!qual_set) begin
                if (!on_timing) begin
                    on_timing   = 1'b1;
                    timer_start = now;
                end else if (elapsed > on_delay_reg) begin
                    on_timing = 1'b0;
                    qual_set  = 1'b1;
                end
            end
        end else begin
            on_timing = 1'b0;
            if (qual_set) begin
                if (!off_timing) begin
                    off_timing  = 1'b1;
                    timer_start = now;
                end else if (elapsed > off_delay_reg) begin
                    qual_set   = 1'b0;
                    off_timing = 1'b0;
                end
            end
        end
        return qual_set;
    endfunction

    // predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_levels.push_back(qualify_sample(s_sensor_level, s_now_tick));
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want_level = expected_levels.pop_front();
                if (m_qualified_level !== want_level)
                    report_mismatch($sformatf("qualified_level got %b expected %b",
                                              m_qualified_level, want_level));
            end
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input logic level, input logic [TICK_W-1:0] tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sensor_level <= level;
        s_now_tick     <= tick;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop offering and let every result come back
    task automatic wait_idle;
        s_valid <= 1'b0;
        // let the last accepted request reach the queue first
        @(posedge aclk);
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write both delay registers, block must be idle
    task automatic set_delays(input logic [DELAY_W-1:0] on_d, input logic [DELAY_W-1:0] off_d);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ON_DELAY;
        cfg_wdata <= on_d;
        @(posedge aclk);
        cfg_index <= CFG_OFF_DELAY;
        cfg_wdata <= off_d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        on_delay_reg  = on_d;
        off_delay_reg = off_d;
    endtask

    // sensor runs of random length on a slowly advancing tick, with some noise
    task automatic drive_sensor_traffic(input int n_items);
        int span;
        int i;
        logic [TICK_W-1:0] tick;
        span = (on_delay_reg > off_delay_reg) ? int'(on_delay_reg) : int'(off_delay_reg);
        if (span > 40)
            span = 40;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 6) begin
                // noise: any level, any tick the port can carry
                send_request(1'($urandom_range(1)), TICK_W'($urandom_range(65535)));
            end else begin
                if (run_left == 0) begin
                    trace_level = ~trace_level;
                    run_left    = $urandom_range(span + 6, 1);
                end
                run_left--;
                if ($urandom_range(99) < 3)
                    trace_tick = (trace_tick + $urandom_range(59999)) % TIMER_MODULUS_DEFAULT;
                else
                    trace_tick = (trace_tick + $urandom_range(3)) % TIMER_MODULUS_DEFAULT;
                tick = TICK_W'(trace_tick);
                // same tick seen beyond the modulus
                if (trace_tick < 65536 - TIMER_MODULUS_DEFAULT && $urandom_range(9) == 0)
                    tick = TICK_W'(trace_tick + TIMER_MODULUS_DEFAULT);
                send_request(trace_level, tick);
            end
        end
    endtask

    // corner cases: first sample, zero delays, wrap, out-of-range ticks, max delays
    task automatic test_directed;
        // first sample active sets at once, tick beyond modulus
        send_request(1'b1, 16'hFFFF);
        send_request(1'b0, 16'd100);
        // active while set cancels the off timer
        send_request(1'b1, 16'd100);
        send_request(1'b0, 16'd200);
        // zero delay never completes on the starting sample
        send_request(1'b0, 16'd200);
        send_request(1'b0, 16'd201);
        send_request(1'b0, 16'd300);
        send_request(1'b1, 16'd59999);
        // inactive while clear cancels the on timer
        send_request(1'b0, 16'd0);
        send_request(1'b1, 16'd59998);
        // wrap through the modulus
        send_request(1'b1, 16'd60000);
        send_request(1'b0, 16'd0);
        wait_idle;
        set_delays(16'd3, 16'd2);
        send_request(1'b0, 16'd5);
        send_request(1'b0, 16'd7);
        send_request(1'b0, 16'd8);
        send_request(1'b1, 16'd59999);
        send_request(1'b1, 16'd2);
        send_request(1'b1, 16'd3);
        send_request(1'b1, 16'hFFFF);
        wait_idle;
        set_delays(16'hFFFF, 16'hFFFF);
        send_request(1'b0, 16'd10);
        send_request(1'b0, 16'd9);
        send_request(1'b0, 16'd0);
        send_request(1'b1, 16'd1);
    endtask

    task automatic test_random_traffic(input int n_items, input logic [DELAY_W-1:0] on_d,
                                       input logic [DELAY_W-1:0] off_d);
        wait_idle;
        set_delays(on_d, off_d);
        drive_sensor_traffic(n_items);
    endtask

    // receiver holds off while requests keep coming, block must stall its input
    task automatic test_stall_fill;
        wait_idle;
        set_delays(16'd4, 16'd6);
        hold_req_cnt <= hold_req_cnt + 1;
        drive_sensor_traffic(80);
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_drain_pause;
        drive_sensor_traffic(30);
        wait_idle;
        drive_sensor_traffic(30);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 19;
        recv_idle_pct = 56;
        test_directed;
        test_random_traffic(350, 16'd0, 16'd0);
        test_random_traffic(300, DELAY_W'($urandom_range(30)), DELAY_W'($urandom_range(30)));

        send_idle_pct = 56;
        recv_idle_pct = 19;
        test_random_traffic(350, 16'd5, 16'd9);
        test_random_traffic(150, 16'hFFFF, 16'hFFFF);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300, 16'd20, 16'd3);
        test_random_traffic(100, 16'd0, 16'hFFFF);
        test_stall_fill;
        test_drain_pause;

        wait_idle;
        repeat (20) @(posedge aclk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        if (error_count == 0)
            $display("tb_presence_sensor_on_off_delay: PASS");
        else
            $display("tb_presence_sensor_on_off_delay: FAIL");
        $finish;
    end

endmodule
